// ===== rtl/nmru_pkg.sv =====
// Shared constants and types for the not-most-recently-used victim selector.
package nmru_pkg;

    // Fixed field widths of the request and result.
    localparam int FUNC_W   = 2;
    localparam int SET_IN_W = 6;
    localparam int WAY_IN_W = 3;
    localparam int TIME_W   = 48;
    localparam int RND_W    = 32;
    localparam int VICT_W   = 3;
    localparam int CFG_W    = 4;

    // Function codes carried by a request.
    localparam logic [FUNC_W-1:0] FUNC_TOUCH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INVAL = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    // Reset value of the ways-in-use register.
    localparam logic [CFG_W-1:0] WAYS_IN_USE_RESET = 4'd8;

    // Random-value bits consumed by the remainder unit in each cycle.
    localparam int MOD_BITS = 8;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUERY
    } t_state;

endpackage

// ===== rtl/nmru_time_ram.sv =====
// Timestamp memory: one row per set, one 48-bit entry per way, per-way write mask.
module nmru_time_ram #(
    parameter int WAYS = 8,
    parameter int SETS = 64,
    parameter int SAW  = 6
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [SAW-1:0]                        i_wr_addr,
    input  logic [WAYS-1:0]                       i_wr_mask,
    input  logic [nmru_pkg::TIME_W-1:0]           i_wr_time,
    input  logic                                  i_rd_en,
    input  logic [SAW-1:0]                        i_rd_addr,
    output logic [WAYS-1:0][nmru_pkg::TIME_W-1:0] o_rd_row
);

    logic [WAYS-1:0][nmru_pkg::TIME_W-1:0] mem [SETS];

    // Masked write: only the selected ways of the row take the new time.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            for (int w = 0; w < WAYS; w++) begin
                if (i_wr_mask[w]) begin
                    mem[i_wr_addr][w] <= i_wr_time;
                end
            end
        end
    end

    // Registered row read, held until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_row <= mem[i_rd_addr];
        end
    end

endmodule

// ===== rtl/nmru_mod_unit.sv =====
// Iterative remainder unit: random value modulo a small divisor, several bits per cycle.
module nmru_mod_unit #(
    parameter int REM_W = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [nmru_pkg::RND_W-1:0]   i_dividend,
    input  logic [REM_W-1:0]             i_divisor,
    output logic                         o_done,
    output logic [REM_W-1:0]             o_rem
);

    localparam int STEPS = nmru_pkg::RND_W / nmru_pkg::MOD_BITS;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic                        r_busy;
    logic [CNT_W-1:0]            r_cnt;
    logic [nmru_pkg::RND_W-1:0]  r_shift;
    logic [REM_W-1:0]            r_div;
    logic [REM_W-1:0]            r_rem;
    logic [REM_W-1:0]            n_rem;
    logic [REM_W:0]              trial;

    // Restoring steps over the top bits of the shifting dividend.
    always_comb begin
        n_rem = r_rem;
        trial = '0;
        for (int b = nmru_pkg::MOD_BITS - 1; b >= 0; b--) begin
            trial = {n_rem, r_shift[nmru_pkg::RND_W - nmru_pkg::MOD_BITS + b]};
            if (trial >= {1'b0, r_div}) begin
                trial = trial - {1'b0, r_div};
            end
            n_rem = trial[REM_W-1:0];
        end
    end

    // Step counter and busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: load operands on start, then consume one group of bits per cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_div   <= i_divisor;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= r_shift << nmru_pkg::MOD_BITS;
            r_rem   <= n_rem;
        end
    end

    assign o_done = !r_busy;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/nmru_victim_select.sv =====
// Top level: a touch or invalidate request writes its row at the edge that accepts it.
// A victim query reads its set row at the accepting edge, then holds the block in the query
// state until the one-way-per-cycle MRU scan and the 8-bit-per-cycle remainder unit are both
// done, longer while an earlier result still waits, and registers its result on leaving it.
// Synchronous active-low reset sets ways_in_use to 8; then one set row per cycle is zeroed,
// all SETS rows in turn, and no request is taken until that ends.
module nmru_victim_select #(
    parameter int WAYS = 8,
    parameter int SETS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [nmru_pkg::FUNC_W-1:0]    i_func,
    input  logic [nmru_pkg::SET_IN_W-1:0]  i_set_index,
    input  logic [nmru_pkg::WAY_IN_W-1:0]  i_way_index,
    input  logic [nmru_pkg::TIME_W-1:0]    i_now_time,
    input  logic [nmru_pkg::RND_W-1:0]     i_random_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [nmru_pkg::VICT_W-1:0]    o_victim_way,
    input  logic                           i_cfg_we,
    input  logic [nmru_pkg::CFG_W-1:0]     i_cfg_wdata
);

    localparam int WW   = $clog2(WAYS);
    localparam int NW   = $clog2(WAYS + 1);
    localparam int SAW  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int CW   = (NW > nmru_pkg::CFG_W) ? NW : nmru_pkg::CFG_W;
    localparam int VXW  = (WW > nmru_pkg::VICT_W) ? WW : nmru_pkg::VICT_W;

    // Set index reduced modulo SETS by shifted constant subtraction.
    function automatic logic [SAW-1:0] set_mod(input logic [nmru_pkg::SET_IN_W-1:0] v);
        int r;
        r = int'(v);
        for (int b = nmru_pkg::SET_IN_W - 1; b >= 0; b--) begin
            if (r >= (SETS << b)) begin
                r = r - (SETS << b);
            end
        end
        return SAW'(r);
    endfunction

    nmru_pkg::t_state r_state, n_state;

    logic [nmru_pkg::CFG_W-1:0]       r_ways_in_use;
    logic [SAW-1:0]                   r_clr_addr;
    logic [NW-1:0]                    r_n;
    logic [NW-1:0]                    r_idx;
    logic [WW-1:0]                    r_mru;
    logic [nmru_pkg::TIME_W-1:0]      r_mru_time;
    logic                             r_out_valid;
    logic [nmru_pkg::VICT_W-1:0]      r_victim;

    logic [CW-1:0]                    cfg_ext;
    logic [NW-1:0]                    act_n;
    logic                             accept;
    logic                             is_query;
    logic                             is_write;
    logic [SAW-1:0]                   req_set;
    logic [WAYS-1:0]                  touch_mask;

    logic                             ram_wr_en;
    logic [SAW-1:0]                   ram_wr_addr;
    logic [WAYS-1:0]                  ram_wr_mask;
    logic [nmru_pkg::TIME_W-1:0]      ram_wr_time;
    logic                             ram_rd_en;
    logic [WAYS-1:0][nmru_pkg::TIME_W-1:0] ram_row;

    logic                             mod_done;
    logic [WW-1:0]                    mod_rem;
    logic                             clr_last;
    logic                             scan_done;
    logic                             finish;
    logic [nmru_pkg::TIME_W-1:0]      cand_time;
    logic [WW-1:0]                    victim;
    logic [VXW-1:0]                   victim_ext;

    // Effective number of ways: zero counts as one, anything above WAYS counts as WAYS.
    always_comb begin
        cfg_ext = CW'(r_ways_in_use);
        if (cfg_ext == '0) begin
            act_n = NW'(1);
        end else if (cfg_ext > CW'(WAYS)) begin
            act_n = NW'(WAYS);
        end else begin
            act_n = NW'(cfg_ext);
        end
    end

    // Request decode.
    always_comb begin
        req_set  = set_mod(i_set_index);
        is_query = (i_func == nmru_pkg::FUNC_QUERY);
        is_write = (i_func == nmru_pkg::FUNC_TOUCH) || (i_func == nmru_pkg::FUNC_INVAL);
        for (int w = 0; w < WAYS; w++) begin
            touch_mask[w] = (int'(i_way_index) == w);
        end
    end

    assign clr_last  = (r_clr_addr == SAW'(SETS - 1));
    assign scan_done = (r_idx >= r_n);
    assign cand_time = ram_row[r_idx[WW-1:0]];

    // Victim: skip over the MRU way; a single way in use always gives way 0.
    always_comb begin
        if (r_n == NW'(1)) begin
            victim = '0;
        end else if (mod_rem >= r_mru) begin
            victim = mod_rem + 1'b1;
        end else begin
            victim = mod_rem;
        end
        victim_ext = VXW'(victim);
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nmru_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    n_state = nmru_pkg::ST_IDLE;
                end
            end
            nmru_pkg::ST_IDLE: begin
                if (i_in_valid && is_query) begin
                    n_state = nmru_pkg::ST_QUERY;
                end
            end
            nmru_pkg::ST_QUERY: begin
                if (scan_done && mod_done && (!r_out_valid || i_out_ready)) begin
                    n_state = nmru_pkg::ST_IDLE;
                end
            end
            default: n_state = nmru_pkg::ST_IDLE;
        endcase
    end

    // Output and memory-port control.
    always_comb begin
        o_in_ready  = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = req_set;
        ram_wr_mask = touch_mask;
        ram_wr_time = (i_func == nmru_pkg::FUNC_TOUCH) ? i_now_time : '0;
        ram_rd_en   = 1'b0;
        finish      = 1'b0;
        unique case (r_state)
            nmru_pkg::ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr_addr;
                ram_wr_mask = '1;
                ram_wr_time = '0;
            end
            nmru_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                ram_wr_en  = i_in_valid && is_write;
                ram_rd_en  = i_in_valid && is_query;
            end
            nmru_pkg::ST_QUERY: begin
                finish = scan_done && mod_done && (!r_out_valid || i_out_ready);
            end
            default: ;
        endcase
    end

    assign accept = i_in_valid && o_in_ready;

    // Control registers: state, clearing address, configuration, result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= nmru_pkg::ST_CLEAR;
            r_clr_addr    <= '0;
            r_ways_in_use <= nmru_pkg::WAYS_IN_USE_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == nmru_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_we) begin
                r_ways_in_use <= i_cfg_wdata;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // MRU scan: one way per cycle, strict compare keeps the lowest index on ties.
    always_ff @(posedge i_clk) begin
        if (accept && is_query) begin
            r_n   <= act_n;
            r_idx <= '0;
            r_mru <= '0;
        end else if (r_state == nmru_pkg::ST_QUERY && !scan_done) begin
            if ((r_idx == '0) || (cand_time > r_mru_time)) begin
                r_mru      <= r_idx[WW-1:0];
                r_mru_time <= cand_time;
            end
            r_idx <= r_idx + 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_victim <= victim_ext[nmru_pkg::VICT_W-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_victim_way = r_victim;

    nmru_time_ram #(
        .WAYS (WAYS),
        .SETS (SETS),
        .SAW  (SAW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_mask (ram_wr_mask),
        .i_wr_time (ram_wr_time),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (req_set),
        .o_rd_row  (ram_row)
    );

    nmru_mod_unit #(
        .REM_W (WW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept && is_query),
        .i_dividend (i_random_value),
        .i_divisor  (WW'(act_n - 1'b1)),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

endmodule

// ===== bench/tb.sv =====
// Testbench for nmru_victim_select: directed and random requests checked against a local predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WAYS          = 8;
    localparam int SETS          = 64;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_COUNT   = 12;
    localparam int PHASE_ITEMS   = 90;

    // Field widths taken from the shared package.
    localparam int FUNC_W   = nmru_pkg::FUNC_W;
    localparam int SET_IN_W = nmru_pkg::SET_IN_W;
    localparam int WAY_IN_W = nmru_pkg::WAY_IN_W;
    localparam int TIME_W   = nmru_pkg::TIME_W;
    localparam int RND_W    = nmru_pkg::RND_W;
    localparam int VICT_W   = nmru_pkg::VICT_W;
    localparam int CFG_W    = nmru_pkg::CFG_W;

    // Function code that the block must ignore.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        logic [FUNC_W-1:0]   func;
        logic [SET_IN_W-1:0] set_index;
        logic [WAY_IN_W-1:0] way_index;
        logic [TIME_W-1:0]   now_time;
        logic [RND_W-1:0]    random_value;
    } t_access;

    typedef struct {
        logic [SET_IN_W-1:0] set_index;
        logic [VICT_W-1:0]   victim;
    } t_victim;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic                o_in_ready;
    logic [FUNC_W-1:0]   i_func         = '0;
    logic [SET_IN_W-1:0] i_set_index    = '0;
    logic [WAY_IN_W-1:0] i_way_index    = '0;
    logic [TIME_W-1:0]   i_now_time     = '0;
    logic [RND_W-1:0]    i_random_value = '0;
    logic                o_out_valid;
    logic                i_out_ready    = 1'b0;
    logic [VICT_W-1:0]   o_victim_way;
    logic                i_cfg_we       = 1'b0;
    logic [CFG_W-1:0]    i_cfg_wdata    = '0;

    // Predictor state: per-way touch times and the ways-in-use register.
    logic [TIME_W-1:0] touch_time [SETS][WAYS];
    logic [CFG_W-1:0]  ways_in_use_q = nmru_pkg::WAYS_IN_USE_RESET;
    t_victim           expected_victims [$];

    int                mismatches      = 0;
    int                cycle_count     = 0;
    int                send_gap_max    = 9;
    int                ready_stall_max = 9;
    int                hold_off_cycles = 0;
    logic [TIME_W-1:0] access_clock    = '0;

    nmru_victim_select #(
        .WAYS(WAYS),
        .SETS(SETS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_set_index    (i_set_index),
        .i_way_index    (i_way_index),
        .i_now_time     (i_now_time),
        .i_random_value (i_random_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_victim_way   (o_victim_way),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Pick the victim: skip the most recently used way among the ways in use.
    function automatic logic [VICT_W-1:0] choose_victim(input logic [SET_IN_W-1:0] set_index,
                                                        input logic [RND_W-1:0] rnd);
        int unsigned n;
        int unsigned mru;
        int unsigned pick;
        int unsigned way;
        if (ways_in_use_q == 0) n = 1;
        else if (ways_in_use_q > WAYS) n = WAYS;
        else n = 32'(ways_in_use_q);
        if (n == 1) return '0;
        mru = 0;
        for (way = 1; way < n; way++) begin
            if (touch_time[set_index][way] > touch_time[set_index][mru]) mru = way;
        end
        pick = rnd % (n - 1);
        return VICT_W'((pick >= mru) ? pick + 1 : pick);
    endfunction

    // Update the predicted store for an accepted request, or queue the expected victim.
    task automatic update_store(input t_access req);
        t_victim want;
        case (req.func)
            nmru_pkg::FUNC_TOUCH: begin
                touch_time[req.set_index][req.way_index] = req.now_time;
            end
            nmru_pkg::FUNC_INVAL: begin
                touch_time[req.set_index][req.way_index] = '0;
            end
            nmru_pkg::FUNC_QUERY: begin
                want.set_index = req.set_index;
                want.victim    = choose_victim(req.set_index, req.random_value);
                expected_victims.push_back(want);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    function automatic t_access access(input logic [FUNC_W-1:0] func,
                                       input logic [SET_IN_W-1:0] set_index,
                                       input logic [WAY_IN_W-1:0] way_index,
                                       input logic [TIME_W-1:0] now_time,
                                       input logic [RND_W-1:0] random_value);
        t_access req;
        req.func         = func;
        req.set_index    = set_index;
        req.way_index    = way_index;
        req.now_time     = now_time;
        req.random_value = random_value;
        return req;
    endfunction

    // Random request; most go to a small pool of sets so queries see touched rows.
    function automatic t_access random_request(input int set_pool);
        t_access req;
        int      roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) req.func = FUNC_UNUSED;
        else if (roll < 45) req.func = nmru_pkg::FUNC_TOUCH;
        else if (roll < 60) req.func = nmru_pkg::FUNC_INVAL;
        else req.func = nmru_pkg::FUNC_QUERY;
        if ($urandom_range(0, 9) < 7) req.set_index = SET_IN_W'($urandom_range(0, set_pool - 1));
        else req.set_index = SET_IN_W'($urandom);
        req.way_index = WAY_IN_W'($urandom_range(0, WAYS - 1));
        case ($urandom_range(0, 3))
            0, 1: begin
                access_clock = access_clock + TIME_W'($urandom_range(0, 3));
                req.now_time = access_clock;
            end
            2: req.now_time = TIME_W'($urandom_range(0, 3));
            default: req.now_time = TIME_W'({$urandom, $urandom});
        endcase
        if ($urandom_range(0, 1) == 0) req.random_value = $urandom;
        else req.random_value = RND_W'($urandom_range(0, 15));
        return req;
    endfunction

    // Offer one request after a random gap and hold it until it is accepted.
    task automatic send_request(input t_access req);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_func         <= req.func;
        i_set_index    <= req.set_index;
        i_way_index    <= req.way_index;
        i_now_time     <= req.now_time;
        i_random_value <= req.random_value;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        update_store(req);
    endtask

    // Stop offering requests and wait until every expected victim has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_victims.size() != 0) @(posedge i_clk);
    endtask

    // Write ways_in_use only once the block has gone quiet.
    task automatic write_ways_in_use(input logic [CFG_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        ways_in_use_q = value;
    endtask

    // Queries on the cleared store: all ways tie, so way 0 is the MRU.
    task automatic test_reset_state();
        send_request(access(nmru_pkg::FUNC_QUERY, 6'd0, 3'd0, '0, '0));
        send_request(access(nmru_pkg::FUNC_QUERY, 6'd63, 3'd7, '1, '1));
    endtask

    // Extreme field values, ties on the timestamp and the ignored function code.
    task automatic test_field_extremes();
        send_request(access(nmru_pkg::FUNC_TOUCH, 6'd63, 3'd7, '1, '0));
        send_request(access(nmru_pkg::FUNC_TOUCH, 6'd63, 3'd0, 48'd1, '1));
        send_request(access(nmru_pkg::FUNC_QUERY, 6'd63, 3'd0, '0, '0));
        send_request(access(nmru_pkg::FUNC_QUERY, 6'd63, 3'd7, '0, '1));
        send_request(access(nmru_pkg::FUNC_INVAL, 6'd63, 3'd7, '1, '1));
        send_request(access(nmru_pkg::FUNC_QUERY, 6'd63, 3'd0, '0, 32'd6));
        send_request(access(nmru_pkg::FUNC_TOUCH, 6'd0, 3'd3, 48'd5, '0));
        send_request(access(nmru_pkg::FUNC_TOUCH, 6'd0, 3'd5, 48'd5, '0));
        send_request(access(nmru_pkg::FUNC_QUERY, 6'd0, 3'd0, '0, 32'd2));
        send_request(access(nmru_pkg::FUNC_QUERY, 6'd0, 3'd0, '0, 32'd3));
        send_request(access(FUNC_UNUSED, '1, '1, '1, '1));
        send_request(access(nmru_pkg::FUNC_QUERY, 6'd63, 3'd0, '0, 32'd1));
    endtask

    // One way in use, zero counted as one, and values above the way count.
    task automatic test_ways_in_use_limits();
        write_ways_in_use(4'd1);
        send_request(access(nmru_pkg::FUNC_QUERY, 6'd0, 3'd0, '0, '1));
        write_ways_in_use(4'd0);
        send_request(access(nmru_pkg::FUNC_QUERY, 6'd0, 3'd0, '0, 32'd12345));
        write_ways_in_use(4'd15);
        send_request(access(nmru_pkg::FUNC_QUERY, 6'd0, 3'd0, '0, 32'd6));
        write_ways_in_use(4'd9);
        send_request(access(nmru_pkg::FUNC_QUERY, 6'd0, 3'd0, '0, 32'd13));
        write_ways_in_use(4'd2);
        send_request(access(nmru_pkg::FUNC_QUERY, 6'd0, 3'd0, '0, 32'd1));
        write_ways_in_use(4'd8);
    endtask

    // The receiver holds off for a long stretch while queries keep coming.
    task automatic test_backpressure();
        send_gap_max    = 0;
        hold_off_cycles = 300;
        repeat (16) begin
            send_request(access(nmru_pkg::FUNC_QUERY, SET_IN_W'($urandom), '0, '0, $urandom));
        end
        repeat (24) send_request(random_request(4));
        send_gap_max = 9;
    endtask

    // The sender pauses until every expected victim has arrived, then resumes.
    task automatic test_drain_pause();
        repeat (30) send_request(random_request(2));
        wait_drained();
        repeat (30) send_request(random_request(2));
    endtask

    // Random traffic in phases, each with its own ways-in-use value and idling.
    task automatic test_random_traffic();
        logic [CFG_W-1:0] phase_ways [PHASE_COUNT];
        t_access          req;
        int               sent;
        int               pool;
        phase_ways = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd2, 4'd9, 4'd5, 4'd7, 4'd4, 4'd6, 4'd8};
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            write_ways_in_use(phase_ways[phase]);
            case (phase % 4)
                0: begin send_gap_max = 9; ready_stall_max = 9; end
                1: begin send_gap_max = 0; ready_stall_max = 0; end
                2: begin send_gap_max = 0; ready_stall_max = 9; end
                default: begin send_gap_max = 9; ready_stall_max = 0; end
            endcase
            if (phase % 3 == 0) pool = SETS;
            else if (phase % 3 == 1) pool = 4;
            else pool = 1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                req = random_request(pool);
                send_request(req);
                if (req.func != FUNC_UNUSED) sent++;
            end
        end
        send_gap_max    = 9;
        ready_stall_max = 9;
    endtask

    // Receiver: random stall per result, then check it against the oldest expectation.
    initial begin : result_checker
        t_victim want;
        int      stall;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                stall = $urandom_range(0, ready_stall_max);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            if (expected_victims.size() == 0) begin
                report_mismatch($sformatf("victim %0d with no query pending", o_victim_way));
            end else begin
                want = expected_victims.pop_front();
                if (o_victim_way !== want.victim) begin
                    report_mismatch($sformatf("set %0d: victim %0d, expected %0d",
                                              want.set_index, o_victim_way, want.victim));
                end
            end
        end
    end

    // Cycle counter that ends a hung run.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** nmru_victim_select: FAILED **");
        $finish;
    end

    // Test sequence.
    initial begin : test_sequence
        foreach (touch_time[s, w]) touch_time[s][w] = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_field_extremes();
        test_ways_in_use_limits();
        test_backpressure();
        test_drain_pause();
        test_random_traffic();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("** nmru_victim_select: PASSED **");
        end else begin
            $display("** nmru_victim_select: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/nmru_pkg.sv
rtl/nmru_time_ram.sv
rtl/nmru_mod_unit.sv
rtl/nmru_victim_select.sv
bench/tb.sv
